// ===== design/servo_pulse_interpolator_assert.svh =====
// ----------------------------------------------------------------------------
// Servo pulse interpolator assertion macros
// Short forms for clocked properties with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef SERVO_PULSE_INTERPOLATOR_ASSERT_SVH
`define SERVO_PULSE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define SPINT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SPINT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/spint_pkg.sv =====
// ----------------------------------------------------------------------------
// spint_pkg
// Types and constants shared by the servo pulse interpolator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spint_pkg;

    // Field widths
    localparam int DUTY_W    = 12;
    localparam int CHAN_W    = 3;
    localparam int TIME_W    = 16;
    localparam int MDUR_W    = 15;
    localparam int TICK_W    = 11;
    localparam int OFF_W     = 12;
    localparam int MAG_W     = 11;
    localparam int PROD_W    = MAG_W + TICK_W;
    localparam int DIV_W     = TICK_W + 10;
    localparam int Q_W       = 11;
    localparam int DIV_STEPS = Q_W;
    localparam int CNT_W     = 4;
    localparam int NUM_DUTY_OUT = 8;

    // Limits and reset values
    localparam logic [DUTY_W-1:0] PULSE_MIN   = 12'd500;
    localparam logic [DUTY_W-1:0] PULSE_MAX   = 12'd2500;
    localparam logic [TIME_W-1:0] TIME_MIN    = 16'd20;
    localparam logic [TIME_W-1:0] TIME_MAX    = 16'd30000;
    localparam logic [MDUR_W-1:0] MDUR_RESET  = 15'd2000;
    // ms to 20 ms ticks: (x * 52429) >> 20 is exact for x <= 30000
    localparam logic [15:0]       RECIP20     = 16'd52429;
    localparam int                RECIP_SHIFT = 20;
    localparam logic [CNT_W-1:0]  DIV_LAST    = 4'(DIV_STEPS - 1);

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic              op;
        logic [CHAN_W-1:0] channel;
        logic [DUTY_W-1:0] pulse;
        logic [TIME_W-1:0] move_time;
    } in_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_ch0;
        logic [DUTY_W-1:0] duty_ch1;
        logic [DUTY_W-1:0] duty_ch2;
        logic [DUTY_W-1:0] duty_ch3;
        logic [DUTY_W-1:0] duty_ch4;
        logic [DUTY_W-1:0] duty_ch5;
        logic [DUTY_W-1:0] duty_ch6;
        logic [DUTY_W-1:0] duty_ch7;
        logic              moving;
        logic [TICK_W-1:0] ticks_left;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic apply_set;
        logic load;
        logic decrement;
        logic finish;
        logic mul;
        logic div_step;
        logic write;
        logic publish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op;
        logic pending;
        logic active;
        logic rem_zero;
        logic div_last;
        logic chan_last;
        logic out_busy;
    } sts_t;

    // Power-up pulse width per channel
    function automatic logic [DUTY_W-1:0] reset_duty(input int ch);
        logic [DUTY_W-1:0] v;
        case (ch)
            3, 4: v = 12'd500;
            5:    v = 12'd900;
            default: v = 12'd1500;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/spint_ctrl.sv =====
// ----------------------------------------------------------------------------
// spint_ctrl
// Sequencer: runs one request through set, ramp update and per-channel
// multiply/divide, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spint_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output spint_pkg::cmd_t      cmd,
    input  wire spint_pkg::sts_t sts
);
    import spint_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_OP    = 8'b0000_0010,
        ST_STEP  = 8'b0000_0100,
        ST_EVAL  = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_WRITE = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_OP;
                end
            end
            ST_OP: begin
                if (sts.op == OP_SET) begin
                    cmd.apply_set = 1'b1;
                    state_next    = ST_DONE;
                end else begin
                    cmd.load   = sts.pending;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (sts.active) begin
                    cmd.decrement = 1'b1;
                    state_next    = ST_EVAL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_EVAL: begin
                if (sts.rem_zero) begin
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write  = 1'b1;
                state_next = sts.chan_last ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/spint_datapath.sv =====
// ----------------------------------------------------------------------------
// spint_datapath
// Channel state, ramp counters, shared multiplier and radix-2 divider,
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spint_datapath #(
    parameter int NUM_CHANNELS = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire spint_pkg::cmd_t  cmd,
    output spint_pkg::sts_t       sts,
    input  wire spint_pkg::in_t   s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output spint_pkg::out_t       m_data
);
    import spint_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    // Per-channel state
    logic [DUTY_W-1:0] cur_reg [NUM_CHANNELS];
    logic [DUTY_W-1:0] cur_next[NUM_CHANNELS];
    logic [DUTY_W-1:0] tgt_reg [NUM_CHANNELS];
    logic [DUTY_W-1:0] tgt_next[NUM_CHANNELS];
    logic [OFF_W-1:0]  off_reg [NUM_CHANNELS];
    logic [OFF_W-1:0]  off_next[NUM_CHANNELS];

    // Ramp control state
    logic [MDUR_W-1:0] mdur_reg, mdur_next;
    logic [TICK_W-1:0] total_reg, total_next;
    logic [TICK_W-1:0] rem_reg, rem_next;
    logic              pending_reg, pending_next;
    logic              active_reg, active_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    // Request and divider working registers
    in_t               in_reg, in_next;
    logic [PROD_W-1:0] r_reg, r_next;
    logic [DIV_W-1:0]  d_reg, d_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    out_t              out_reg, out_next;

    logic              set_ok;
    logic [TIME_W-1:0] time_clamped;
    logic [30:0]       tprod;
    logic [TICK_W-1:0] total_calc;
    logic [OFF_W-1:0]  off_sel;
    logic [OFF_W-1:0]  off_abs;
    logic              div_ge;
    logic [DUTY_W:0]   sum;
    logic [DUTY_W-1:0] duty_view[NUM_DUTY_OUT];

    // Set validity and move time clamp
    assign set_ok = (32'(in_reg.channel) < 32'(NUM_CHANNELS)) &&
                    (in_reg.pulse >= PULSE_MIN) && (in_reg.pulse <= PULSE_MAX);
    assign time_clamped = (in_reg.move_time < TIME_MIN) ? TIME_MIN :
                          (in_reg.move_time > TIME_MAX) ? TIME_MAX : in_reg.move_time;

    // Ramp length in ticks: move duration / 20 by reciprocal
    assign tprod      = 31'(mdur_reg) * 31'(RECIP20);
    assign total_calc = tprod[RECIP_SHIFT +: TICK_W];

    // Operand select for the shared multiplier
    assign off_sel = off_reg[idx_reg];
    assign off_abs = off_sel[OFF_W-1] ? (~off_sel + 1'b1) : off_sel;

    // Divider compare
    assign div_ge = (r_reg >= {1'b0, d_reg});

    // target + signed quotient, kept to 12 bits
    assign sum = {1'b0, tgt_reg[idx_reg]} +
                 (neg_reg ? (~{2'b00, q_reg} + 1'b1) : {2'b00, q_reg});

    // Status to the controller
    assign sts.op        = in_reg.op;
    assign sts.pending   = pending_reg;
    assign sts.active    = active_reg;
    assign sts.rem_zero  = (rem_reg == '0);
    assign sts.div_last  = (cnt_reg == DIV_LAST);
    assign sts.chan_last = (idx_reg == LAST_IDX);
    assign sts.out_busy  = m_valid_reg && !m_ready;

    // Reported duties; missing channels read zero
    for (genvar j = 0; j < NUM_DUTY_OUT; j++) begin : g_view
        if (j < NUM_CHANNELS) begin : g_has
            assign duty_view[j] = cur_reg[j];
        end else begin : g_none
            assign duty_view[j] = '0;
        end
    end

    // Next-state logic
    always_comb begin
        in_next      = in_reg;
        cur_next     = cur_reg;
        tgt_next     = tgt_reg;
        off_next     = off_reg;
        mdur_next    = mdur_reg;
        total_next   = total_reg;
        rem_next     = rem_reg;
        pending_next = pending_reg;
        active_next  = active_reg;
        idx_next     = idx_reg;
        r_next       = r_reg;
        d_next       = d_reg;
        q_next       = q_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;

        if (cmd.capture) begin
            in_next = s_data;
        end

        // Set request: new target and move time
        if (cmd.apply_set && set_ok) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (32'(in_reg.channel) == 32'(i)) begin
                    tgt_next[i] = in_reg.pulse;
                end
            end
            mdur_next    = time_clamped[MDUR_W-1:0];
            pending_next = 1'b1;
        end

        // Start a new ramp from the current duties
        if (cmd.load) begin
            pending_next = 1'b0;
            total_next   = total_calc;
            rem_next     = total_calc;
            active_next  = 1'b1;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                off_next[i] = OFF_W'({1'b0, cur_reg[i]} - {1'b0, tgt_reg[i]});
            end
        end

        if (cmd.decrement) begin
            if (rem_reg != '0) begin
                rem_next = rem_reg - 1'b1;
            end
            idx_next = '0;
        end

        // End of ramp: snap to targets
        if (cmd.finish) begin
            cur_next    = tgt_reg;
            active_next = 1'b0;
        end

        // |offset| * remaining, divider setup
        if (cmd.mul) begin
            r_next   = PROD_W'(off_abs[MAG_W-1:0]) * PROD_W'(rem_reg);
            d_next   = {total_reg, 10'b0};
            q_next   = '0;
            neg_next = off_sel[OFF_W-1];
            cnt_next = '0;
        end

        // One quotient bit per cycle
        if (cmd.div_step) begin
            if (div_ge) begin
                r_next = r_reg - {1'b0, d_reg};
            end
            q_next   = {q_reg[Q_W-2:0], div_ge};
            d_next   = d_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.write) begin
            cur_next[idx_reg] = sum[DUTY_W-1:0];
            idx_next          = idx_reg + 1'b1;
        end

        // Result snapshot
        if (cmd.publish) begin
            m_valid_next        = 1'b1;
            out_next.duty_ch0   = duty_view[0];
            out_next.duty_ch1   = duty_view[1];
            out_next.duty_ch2   = duty_view[2];
            out_next.duty_ch3   = duty_view[3];
            out_next.duty_ch4   = duty_view[4];
            out_next.duty_ch5   = duty_view[5];
            out_next.duty_ch6   = duty_view[6];
            out_next.duty_ch7   = duty_view[7];
            out_next.moving     = active_reg;
            out_next.ticks_left = rem_reg;
        end
    end

    // State with defined reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                cur_reg[i] <= reset_duty(i);
                tgt_reg[i] <= reset_duty(i);
                off_reg[i] <= '0;
            end
            mdur_reg    <= MDUR_RESET;
            total_reg   <= '0;
            rem_reg     <= '0;
            pending_reg <= 1'b1;
            active_reg  <= 1'b0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_reg     <= cur_next;
            tgt_reg     <= tgt_next;
            off_reg     <= off_next;
            mdur_reg    <= mdur_next;
            total_reg   <= total_next;
            rem_reg     <= rem_next;
            pending_reg <= pending_next;
            active_reg  <= active_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== design/servo_pulse_interpolator.sv =====
// A set request passes ST_OP then ST_DONE. A tick passes ST_OP and ST_STEP, and during
// a ramp ST_EVAL; unless it is the final tick, each channel then visits ST_MUL on one
// shared multiplier, the 11-step divider in ST_DIV and ST_WRITE, before ST_DONE.
// One request in flight: the next is accepted in the same cycle the result is
// presented, while that result may still wait in the output register.
// Reset (aresetn low, synchronous) restores power-up duties, no ramp, change pending.
`default_nettype none

module servo_pulse_interpolator #(
    parameter int NUM_CHANNELS = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire spint_pkg::in_t   s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output spint_pkg::out_t       m_data
);
    import spint_pkg::*;

    `include "servo_pulse_interpolator_assert.svh"

    cmd_t cmd;
    sts_t sts;

    spint_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    spint_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Checks
    `SPINT_ASSERT_NEXT(a_busy_after_req, aclk, aresetn, s_valid && s_ready, !s_ready, "accepted request did not make block busy")
    `SPINT_ASSERT_NEXT(a_publish_valid, aclk, aresetn, cmd.publish, m_valid, "published result not presented")
    `SPINT_ASSERT_SAME(a_idle_no_ticks, aclk, aresetn, m_valid && !m_data.moving, m_data.ticks_left == '0, "ticks left while ramp stopped")
    `SPINT_ASSERT_SAME(a_ticks_bound, aclk, aresetn, m_valid, m_data.ticks_left <= 11'd1500, "ticks left beyond longest ramp")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: servo pulse interpolator testbench
// Drives set and tick requests into the block, with a directed table first
// and then random ramp sequences under several idle/stall mixes. Each report
// is checked field by field against a table value or an in-bench ramp model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import spint_pkg::*;

    localparam int NCH            = 8;
    localparam int TICK_MS        = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 150;
    localparam int PHASE_ITEMS    = 425;

    // Reports that the directed table can state directly
    localparam out_t AT_RESET = {12'd1500, 12'd1500, 12'd1500, 12'd500,
                                 12'd500, 12'd900, 12'd1500, 12'd1500, 1'b0, 11'd0};
    localparam out_t RAMP_FROM_RESET = {12'd1500, 12'd1500, 12'd1500, 12'd500,
                                        12'd500, 12'd900, 12'd1500, 12'd1500, 1'b1, 11'd99};
    localparam out_t CH0_LOW = {12'd500, 12'd1500, 12'd1500, 12'd500,
                                12'd500, 12'd900, 12'd1500, 12'd1500, 1'b0, 11'd0};
    localparam out_t CH7_HIGH = {12'd500, 12'd1500, 12'd1500, 12'd500,
                                 12'd500, 12'd900, 12'd1500, 12'd2500, 1'b0, 11'd0};

    typedef struct {
        in_t  req;
        bit   fixed;
        out_t want;
    } dir_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    // Ramp model state
    logic [DUTY_W-1:0] duty_now [NCH];
    logic [DUTY_W-1:0] duty_goal [NCH];
    int                ramp_offset [NCH];
    int                move_ms;
    int                ramp_len;
    int                ticks_rem;
    bit                change_flag;
    bit                ramping;

    out_t     duty_reports_q [$];
    dir_row_t dir_rows [$];

    int idle_pct;
    int stall_pct;
    int hold_left;
    int idle_cycles;
    int reqs_sent;
    int reports_checked;
    int ramps_started;
    int mismatches;

    servo_pulse_interpolator u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Next report for one accepted request; updates the ramp state
    function automatic out_t ramp_predict(in_t req);
        out_t rpt;
        int   t;
        int   d;
        if (req.op == OP_SET) begin
            if (int'(req.channel) < NCH && req.pulse >= PULSE_MIN
                    && req.pulse <= PULSE_MAX) begin
                t = int'(req.move_time);
                if (t < int'(TIME_MIN)) t = int'(TIME_MIN);
                if (t > int'(TIME_MAX)) t = int'(TIME_MAX);
                duty_goal[req.channel] = req.pulse;
                move_ms = t;
                change_flag = 1'b1;
            end
        end else begin
            // pending change: latch offsets and start a fresh ramp
            if (change_flag) begin
                change_flag = 1'b0;
                ramp_len = move_ms / TICK_MS;
                if (ramp_len == 0) ramp_len = 1;
                ticks_rem = ramp_len;
                for (int i = 0; i < NCH; i++)
                    ramp_offset[i] = int'(duty_now[i]) - int'(duty_goal[i]);
                ramping = 1'b1;
                ramps_started++;
            end
            if (ramping) begin
                if (ticks_rem > 0) ticks_rem--;
                for (int i = 0; i < NCH; i++) begin
                    if (ticks_rem == 0) begin
                        duty_now[i] = duty_goal[i];
                    end else begin
                        // truncates toward zero, as the block does
                        d = (ramp_offset[i] * ticks_rem) / ramp_len;
                        duty_now[i] = DUTY_W'(int'(duty_goal[i]) + d);
                    end
                end
                if (ticks_rem == 0) ramping = 1'b0;
            end
        end
        rpt.duty_ch0   = duty_now[0];
        rpt.duty_ch1   = duty_now[1];
        rpt.duty_ch2   = duty_now[2];
        rpt.duty_ch3   = duty_now[3];
        rpt.duty_ch4   = duty_now[4];
        rpt.duty_ch5   = duty_now[5];
        rpt.duty_ch6   = duty_now[6];
        rpt.duty_ch7   = duty_now[7];
        rpt.moving     = ramping;
        rpt.ticks_left = TICK_W'(ticks_rem);
        return rpt;
    endfunction

    function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one request, optionally after an idle gap, and log its report
    task automatic send_req(in_t req, bit fixed, out_t want);
        int   gap;
        out_t predicted;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predicted = ramp_predict(req);
        duty_reports_q.push_back(fixed ? want : predicted);
        reqs_sent++;
    endtask

    // Sender pauses until every report has come back
    task automatic drain_reports();
        s_valid <= 1'b0;
        do @(posedge aclk); while (duty_reports_q.size() != 0);
    endtask

    task automatic add_row(logic op, int ch, int pulse, int mt, bit fixed, out_t want);
        dir_row_t row;
        row.req.op        = op;
        row.req.channel   = CHAN_W'(ch);
        row.req.pulse     = DUTY_W'(pulse);
        row.req.move_time = TIME_W'(mt);
        row.fixed         = fixed;
        row.want          = want;
        dir_rows.push_back(row);
    endtask

    // Mostly valid sets followed by runs of ticks, with some fully random requests
    task automatic random_traffic(int n_items);
        int   counted;
        int   nsets;
        int   nticks;
        int   mt_ms;
        in_t  req;
        out_t no_report;
        counted   = 0;
        no_report = '0;
        while (counted < n_items) begin
            if ($urandom_range(99) < 15) begin
                req = in_t'($urandom);
                send_req(req, 1'b0, no_report);
                if (req.op == OP_TICK || (req.pulse >= PULSE_MIN && req.pulse <= PULSE_MAX))
                    counted++;
            end else begin
                case ($urandom_range(9))
                    0:       mt_ms = $urandom_range(65535);
                    1:       mt_ms = $urandom_range(19);
                    2:       mt_ms = $urandom_range(65535, 30000);
                    default: mt_ms = $urandom_range(800, 20);
                endcase
                nsets = $urandom_range(3, 1);
                repeat (nsets) begin
                    req.op        = OP_SET;
                    req.channel   = CHAN_W'($urandom_range(7));
                    req.pulse     = DUTY_W'($urandom_range(2500, 500));
                    req.move_time = TIME_W'(mt_ms);
                    send_req(req, 1'b0, no_report);
                    counted++;
                end
                nticks = $urandom_range(45, 1);
                repeat (nticks) begin
                    // other fields are don't-care on a tick; keep them random
                    req    = in_t'($urandom);
                    req.op = OP_TICK;
                    send_req(req, 1'b0, no_report);
                    counted++;
                end
            end
        end
    endtask

    // Receiver: random stalls, or a long hold when one is requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Report checker
    always @(posedge aclk) begin : report_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (duty_reports_q.size() == 0) begin
                $display("%0t: report with nothing expected, got %h", $time, m_data);
                mismatches++;
            end else begin
                want = duty_reports_q.pop_front();
                check_field("duty_ch0", want.duty_ch0, m_data.duty_ch0);
                check_field("duty_ch1", want.duty_ch1, m_data.duty_ch1);
                check_field("duty_ch2", want.duty_ch2, m_data.duty_ch2);
                check_field("duty_ch3", want.duty_ch3, m_data.duty_ch3);
                check_field("duty_ch4", want.duty_ch4, m_data.duty_ch4);
                check_field("duty_ch5", want.duty_ch5, m_data.duty_ch5);
                check_field("duty_ch6", want.duty_ch6, m_data.duty_ch6);
                check_field("duty_ch7", want.duty_ch7, m_data.duty_ch7);
                check_field("moving", 12'(want.moving), 12'(m_data.moving));
                check_field("ticks_left", 12'(want.ticks_left), 12'(m_data.ticks_left));
                reports_checked++;
            end
        end
    end

    // Watchdog: cycles without any handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no handshake in %0d cycles, %0d reports outstanding",
                     $time, idle_cycles, duty_reports_q.size());
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        idle_pct        = 0;
        stall_pct       = 0;
        hold_left       = 0;
        idle_cycles     = 0;
        reqs_sent       = 0;
        reports_checked = 0;
        ramps_started   = 0;
        mismatches      = 0;

        // power-up state of the ramp model
        duty_now    = '{12'd1500, 12'd1500, 12'd1500, 12'd500,
                        12'd500, 12'd900, 12'd1500, 12'd1500};
        duty_goal   = duty_now;
        ramp_offset = '{default: 0};
        move_ms     = int'(MDUR_RESET);
        ramp_len    = 0;
        ticks_rem   = 0;
        change_flag = 1'b1;
        ramping     = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table: pulse and time extremes, invalid sets, restarts
        add_row(OP_SET,  0,    0,     0, 1'b1, AT_RESET);        // pulse zero, ignored
        add_row(OP_SET,  7, 4095, 65535, 1'b1, AT_RESET);        // all ones, ignored
        add_row(OP_SET,  3,  499,   100, 1'b1, AT_RESET);        // just below range
        add_row(OP_SET,  4, 2501,   100, 1'b1, AT_RESET);        // just above range
        add_row(OP_TICK, 0,    0,     0, 1'b1, RAMP_FROM_RESET); // pending from reset
        add_row(OP_SET,  0,  500,     0, 1'b1, RAMP_FROM_RESET); // short time, mid-ramp
        add_row(OP_TICK, 0,    0,     0, 1'b1, CH0_LOW);         // one-tick ramp
        add_row(OP_TICK, 5, 4095, 65535, 1'b1, CH0_LOW);         // idle tick
        add_row(OP_SET,  7, 2500,    19, 1'b1, CH0_LOW);         // clamped up
        add_row(OP_TICK, 0,    0,     0, 1'b1, CH7_HIGH);
        add_row(OP_SET,  1, 2500, 65535, 1'b0, '0);              // clamped down
        add_row(OP_TICK, 0,    0,     0, 1'b0, '0);
        add_row(OP_TICK, 0,    0,     0, 1'b0, '0);
        add_row(OP_SET,  2,  500, 30001, 1'b0, '0);              // set during ramp
        add_row(OP_TICK, 0,    0,     0, 1'b0, '0);              // restart
        add_row(OP_SET,  5, 1000,   100, 1'b0, '0);
        add_row(OP_SET,  6, 2000,   100, 1'b0, '0);
        for (int i = 0; i < 6; i++)
            add_row(OP_TICK, 0, 0, 0, 1'b0, '0);
        add_row(OP_SET,  3, 2500,    40, 1'b0, '0);
        add_row(OP_TICK, 0,    0,     0, 1'b0, '0);

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want);
        drain_reports();

        // No idling, with one long receiver hold to back the block up
        hold_left = HOLD_CYCLES;
        random_traffic(PHASE_ITEMS);
        drain_reports();

        idle_pct  = 74;
        stall_pct = 0;
        random_traffic(PHASE_ITEMS);
        drain_reports();

        idle_pct  = 0;
        stall_pct = 74;
        random_traffic(PHASE_ITEMS);
        drain_reports();

        idle_pct  = 27;
        stall_pct = 27;
        random_traffic(PHASE_ITEMS);
        drain_reports();

        // catch any stray report
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("summary: %0d requests (%0d from the table), %0d reports checked",
                 reqs_sent, dir_rows.size(), reports_checked);
        $display("summary: %0d ramps started; idle mixes none/sender/receiver/both",
                 ramps_started);
        if (mismatches == 0 && duty_reports_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/spint_pkg.sv
design/spint_ctrl.sv
design/spint_datapath.sv
design/servo_pulse_interpolator.sv
tb/tb.sv
